[src/i2cm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // command opcodes on the request channel
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_STOP    = 3'd2;
   localparam logic [2:0] OP_WRITE   = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;
   localparam logic [2:0] OP_WAITACK = 3'd5;

   // register file
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam logic        REG_ACK_LIMIT  = 1'b0;
   localparam logic [7:0]  ACK_LIMIT_RESET = 8'd250;

   typedef enum logic [5:0] {
      CMD_IDLE    = 6'b000001,
      CMD_START   = 6'b000010,
      CMD_STOP    = 6'b000100,
      CMD_WRITE   = 6'b001000,
      CMD_READ    = 6'b010000,
      CMD_WAITACK = 6'b100000
   } cmd_state_type;

   typedef struct packed {
      logic          is_cmd;
      cmd_state_type cmd;
      logic [7:0]    write_value;
      logic          send_ack;
      logic          sda_sample;
   } item_type;

endpackage
`default_nettype wire

[src/i2cm_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] write_value;
   logic       send_ack;
   logic       sda_sample;

   modport source (output valid, opcode, write_value, send_ack, sda_sample, input ready);
   modport sink   (input valid, opcode, write_value, send_ack, sda_sample, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive_enable;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_value;
   logic       ack_error;

   modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                   done_res, read_value, ack_error, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                   done_res, read_value, ack_error, output ready);
endinterface
`default_nettype wire

[src/i2cm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests and classifies them as tick or command before queueing.
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   i2cm_req_if.sink  req_if,
   input  wire logic q_ready,
   output logic      q_push,
   output item_type  q_item
);

   assign req_if.ready = q_ready;
   assign q_push       = req_if.valid & q_ready;

   always_comb begin
      q_item.is_cmd      = 1'b1;
      q_item.cmd         = CMD_IDLE;
      q_item.write_value = req_if.write_value;
      q_item.send_ack    = req_if.send_ack;
      q_item.sda_sample  = req_if.sda_sample;
      unique case (req_if.opcode)
         OP_START:   q_item.cmd = CMD_START;
         OP_STOP:    q_item.cmd = CMD_STOP;
         OP_WRITE:   q_item.cmd = CMD_WRITE;
         OP_READ:    q_item.cmd = CMD_READ;
         OP_WAITACK: q_item.cmd = CMD_WAITACK;
         // tick, and the two unused codes that behave as ticks
         default:    q_item.is_cmd = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

[src/i2cm_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO between the request front end and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue
   import i2cm_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          in_ready,
   output logic          out_valid,
   output item_type      out_item,
   input  wire logic     pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

[src/i2cm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// Bus phase sequencer: runs one queued request per cycle while the response
// register is free or being drained, and registers the resulting pin levels and status.
// ----------------------------------------------------------------------------
module i2cm_back
   import i2cm_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic [7:0] ack_limit,
   input  wire logic  q_valid,
   input  wire item_type q_item,
   output logic       q_pop,
   i2cm_rsp_if.source rsp_if
);

   cmd_state_type cmd_ff, cmd_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tcount_ff, tcount_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       sda_en_ff, sda_en_in;
   logic       ack_flag_ff, ack_flag_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       done;
   logic       read_done;

   logic       rsp_valid_ff;
   logic       rsp_scl_ff, rsp_sda_ff, rsp_sda_en_ff;
   logic       rsp_busy_ff, rsp_done_ff, rsp_err_ff;
   logic [7:0] rsp_read_ff;

   // advance whenever the output register is free or being drained
   assign q_pop = q_valid & (!rsp_valid_ff | rsp_if.ready);

   always_comb begin
      cmd_in        = cmd_ff;
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      tcount_in     = tcount_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      sda_en_in     = sda_en_ff;
      ack_flag_in   = ack_flag_ff;
      ack_choice_in = ack_choice_ff;
      done          = 1'b0;
      read_done     = 1'b0;
      if (q_item.is_cmd) begin
         // commands arriving while busy are dropped
         if (cmd_ff == CMD_IDLE) begin
            cmd_in      = q_item.cmd;
            phase_in    = 3'd0;
            bit_in      = 3'd0;
            tcount_in   = 8'd0;
            ack_flag_in = 1'b0;
            if (q_item.cmd == CMD_WRITE) begin
               shift_in = q_item.write_value;
            end
            if (q_item.cmd == CMD_READ) begin
               shift_in      = 8'd0;
               ack_choice_in = q_item.send_ack;
            end
         end
      end else begin
         unique case (cmd_ff)
            CMD_START: begin
               if (phase_ff == 3'd0) begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b1;
                  phase_in  = 3'd1;
               end else if (phase_ff == 3'd1) begin
                  scl_in   = 1'b1;
                  phase_in = 3'd2;
               end else begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b0;
                  cmd_in    = CMD_IDLE;
                  phase_in  = 3'd0;
                  bit_in    = 3'd0;
                  done      = 1'b1;
               end
            end
            CMD_STOP: begin
               if (phase_ff == 3'd0) begin
                  scl_in    = 1'b0;
                  sda_en_in = 1'b1;
                  sda_in    = 1'b0;
                  phase_in  = 3'd1;
               end else if (phase_ff == 3'd1) begin
                  scl_in   = 1'b1;
                  phase_in = 3'd2;
               end else begin
                  sda_en_in = 1'b1;
                  sda_in    = 1'b1;
                  cmd_in    = CMD_IDLE;
                  phase_in  = 3'd0;
                  bit_in    = 3'd0;
                  done      = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (phase_ff == 3'd0) begin
                  scl_in   = 1'b0;
                  phase_in = 3'd1;
               end else if (phase_ff == 3'd1) begin
                  sda_en_in = 1'b1;
                  sda_in    = shift_ff[7];
                  shift_in  = {shift_ff[6:0], 1'b0};
                  phase_in  = 3'd2;
               end else begin
                  scl_in   = 1'b1;
                  phase_in = 3'd0;
                  if (bit_ff == 3'd7) begin
                     cmd_in = CMD_IDLE;
                     bit_in = 3'd0;
                     done   = 1'b1;
                  end else begin
                     bit_in = bit_ff + 3'd1;
                  end
               end
            end
            CMD_READ: begin
               if (phase_ff == 3'd0) begin
                  scl_in    = 1'b0;
                  sda_en_in = 1'b0;
                  phase_in  = 3'd1;
               end else if (phase_ff == 3'd1) begin
                  scl_in   = 1'b1;
                  phase_in = 3'd2;
               end else if (phase_ff == 3'd2) begin
                  shift_in = {shift_ff[6:0], q_item.sda_sample};
                  if (bit_ff == 3'd7) begin
                     phase_in = 3'd3;
                  end else begin
                     phase_in = 3'd0;
                     bit_in   = bit_ff + 3'd1;
                  end
               end else if (phase_ff == 3'd3) begin
                  scl_in   = 1'b0;
                  phase_in = 3'd4;
               end else if (phase_ff == 3'd4) begin
                  sda_en_in = 1'b1;
                  sda_in    = ~ack_choice_ff;
                  phase_in  = 3'd5;
               end else if (phase_ff == 3'd5) begin
                  scl_in   = 1'b1;
                  phase_in = 3'd6;
               end else begin
                  scl_in    = 1'b0;
                  read_done = 1'b1;
                  cmd_in    = CMD_IDLE;
                  phase_in  = 3'd0;
                  bit_in    = 3'd0;
                  done      = 1'b1;
               end
            end
            CMD_WAITACK: begin
               if (phase_ff == 3'd0) begin
                  scl_in    = 1'b0;
                  sda_en_in = 1'b0;
                  phase_in  = 3'd1;
               end else if (phase_ff == 3'd1) begin
                  scl_in    = 1'b1;
                  tcount_in = 8'd0;
                  phase_in  = 3'd2;
               end else if (!q_item.sda_sample) begin
                  scl_in   = 1'b0;
                  cmd_in   = CMD_IDLE;
                  phase_in = 3'd0;
                  bit_in   = 3'd0;
                  done     = 1'b1;
               end else if (tcount_ff >= ack_limit) begin
                  // timed out: flag and hand over to the stop sequence
                  ack_flag_in = 1'b1;
                  cmd_in      = CMD_STOP;
                  phase_in    = 3'd0;
                  bit_in      = 3'd0;
               end else begin
                  tcount_in = tcount_ff + 8'd1;
               end
            end
            CMD_IDLE: begin
               phase_in = 3'd0;
            end
            default: begin
               cmd_in   = CMD_IDLE;
               phase_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= CMD_IDLE;
         phase_ff      <= 3'd0;
         bit_ff        <= 3'd0;
         shift_ff      <= 8'd0;
         tcount_ff     <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         sda_en_ff     <= 1'b1;
         ack_flag_ff   <= 1'b0;
         ack_choice_ff <= 1'b0;
      end else if (q_pop) begin
         cmd_ff        <= cmd_in;
         phase_ff      <= phase_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         tcount_ff     <= tcount_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         sda_en_ff     <= sda_en_in;
         ack_flag_ff   <= ack_flag_in;
         ack_choice_ff <= ack_choice_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_scl_ff    <= scl_in;
         rsp_sda_ff    <= sda_in;
         rsp_sda_en_ff <= sda_en_in;
         rsp_busy_ff   <= (cmd_in != CMD_IDLE);
         rsp_done_ff   <= done;
         rsp_read_ff   <= read_done ? shift_ff : 8'd0;
         rsp_err_ff    <= (cmd_in == CMD_IDLE) & ack_flag_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.scl_level        = rsp_scl_ff;
   assign rsp_if.sda_level        = rsp_sda_ff;
   assign rsp_if.sda_drive_enable = rsp_sda_en_ff;
   assign rsp_if.busy_res         = rsp_busy_ff;
   assign rsp_if.done_res         = rsp_done_ff;
   assign rsp_if.read_value       = rsp_read_ff;
   assign rsp_if.ack_error        = rsp_err_ff;

endmodule
`default_nettype wire

[src/i2c_master_bit_sequencer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// I2C master that steps SCL/SDA one half-period phase per tick request.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries either a command (start, stop, write byte, read byte,
//   wait for ACK) or a tick with the sampled SDA level. Every request yields
//   exactly one response on rsp_if with the SCL level, SDA level and drive
//   enable, busy/done status, the received byte and the ACK timeout flag.
//   A request passes through the queue and the response register; one
//   request per cycle is sustained while rsp_if.ready stays high.
//   A small queue decouples request intake from the sequencer and keeps
//   accepting requests while a response waits in the response register.
//   When rsp_if.ready is low the response holds, the sequencer stops and
//   the queue fills; req_if.ready drops once the queue is full.
//   The APB port holds the ACK timeout limit at offset 0 (reset 250);
//   write it only while no request is outstanding.
//   Reset puts the bus lines high with SDA driven and the sequencer idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit
   import i2cm_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   i2cm_req_if.sink                   req_if,
   i2cm_rsp_if.source                 rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [7:0] ack_limit_ff;
   logic       csr_write;
   logic       csr_hit;
   logic       q_ready;
   logic       q_push;
   item_type   q_in_item;
   logic       q_valid;
   item_type   q_out_item;
   logic       q_pop;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_ACK_LIMIT);
   assign csr_write = psel & penable & pwrite & csr_hit;
   assign prdata    = csr_hit ? {{(CSR_DATA_W - 8){1'b0}}, ack_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_limit_ff <= ACK_LIMIT_RESET;
      end else if (csr_write) begin
         ack_limit_ff <= pwdata[7:0];
      end
   end

   i2cm_front u_front (
      .req_if  (req_if),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_item  (q_in_item)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_item  (q_out_item),
      .pop       (q_pop)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ack_limit (ack_limit_ff),
      .q_valid   (q_valid),
      .q_item    (q_out_item),
      .q_pop     (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire

[src/i2cm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level assertions on the response channel of the I2C sequencer.
// ----------------------------------------------------------------------------
module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_busy,
   input wire logic       rsp_done,
   input wire logic       rsp_ack_error,
   input wire logic [7:0] rsp_read_value
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> !rsp_busy)
      else $error("done reported while still busy");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_error |-> !rsp_busy)
      else $error("ack error reported while busy");

   a_read_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != 8'd0) |-> rsp_done)
      else $error("read byte shown without done");

endmodule

bind i2c_master_bit_sequencer_unit i2cm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_busy       (rsp_if.busy_res),
   .rsp_done       (rsp_if.done_res),
   .rsp_ack_error  (rsp_if.ack_error),
   .rsp_read_value (rsp_if.read_value)
);
`default_nettype wire
